/* hw/rtl/gps_pkg.sv */
package gps_pkg;

    // request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_SPEED = 2'd1,
        REQ_POS   = 2'd2
    } t_req;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ATTR_X   = 3'd0,
        CFG_ATTR_Y   = 3'd1,
        CFG_ATTR_M   = 3'd2,
        CFG_TSTEP    = 3'd3,
        CFG_CUTOFF   = 3'd4,
        CFG_COUNT    = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W = 9;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         particle_index;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_speed_x;
        logic signed [31:0] load_speed_y;
        logic [31:0]        load_mass;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         out_index;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_speed_x;
        logic signed [31:0] out_speed_y;
    } t_out_word;

    // one table entry as held in the particle memory
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic [31:0]        mass;
    } t_entry;

endpackage

/* hw/rtl/gps_ram.sv */
module gps_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gps_sqrt.sv */
module gps_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_n;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] t_val;
    logic [35:0] trial;
    logic        ge;

    // one result bit per cycle: bring down two radicand bits, try root*4+1
    assign t_val = {r_rem, r_n[63:62]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = (t_val >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[61:0], 2'b00};
            r_rem  <= ge ? 34'(t_val - trial) : t_val[33:0];
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hw/rtl/gps_div.sv */
module gps_div #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_r;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   t_val;
    logic [DEN_W:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    assign t_val = {r_r, r_q[NUM_W-1]};
    assign diff  = t_val - {1'b0, r_den};
    assign ge    = (t_val >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_r   <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_r <= ge ? diff[DEN_W-1:0] : t_val[DEN_W-1:0];
            r_q <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hw/rtl/gravity_particle_step.sv */
// A load or an out-of-table request goes straight to its output word; an unknown request
// only reads the addressed entry, a position update moves it and writes it back, and a
// speed update pulls from every other stored entry within the cutoff, then from the
// attractor, skipping pulls at zero distance, and writes the entry back.
// One request at a time; the shared divider (three divisions per pull) and the root unit
// set the cost of each pull. Reset is synchronous, active low; the table stays as is;
// control and configuration are cleared, but the time step is set to 1 << FRAC_BITS.
module gravity_particle_step
    import gps_pkg::*;
#(
    parameter int MAX_PARTICLES = 256,
    parameter int FRAC_BITS     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(MAX_PARTICLES);
    localparam int KW    = $clog2(MAX_PARTICLES + 1);
    localparam int NUM_W = 64 + FRAC_BITS;
    localparam int EW    = $bits(t_entry);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_OWN, ST_SCAN, ST_RD_OTHER, ST_SQX, ST_SQY, ST_SQC, ST_CHK,
        ST_SQRT, ST_DIVP, ST_MULX, ST_MULY, ST_DIVX, ST_DIVY, ST_MVX, ST_MVY,
        ST_MVEND, ST_WB, ST_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic signed [31:0] r_attr_x;
    logic signed [31:0] r_attr_y;
    logic [31:0]        r_attr_m;
    logic [31:0]        r_tstep;
    logic [31:0]        r_cutoff;
    logic [COUNT_W-1:0] r_count;

    // request and addressed entry
    logic [1:0]         r_req;
    logic [7:0]         r_pidx;
    logic [AW-1:0]      r_idx;
    logic signed [31:0] r_own_px;
    logic signed [31:0] r_own_py;
    logic signed [31:0] r_own_sx;
    logic signed [31:0] r_own_sy;
    logic [31:0]        r_own_m;

    // scan and pull
    logic [KW-1:0]      r_k;
    logic [KW-1:0]      r_lim;
    logic               r_attr;
    logic [31:0]        r_om;
    logic [31:0]        r_ax;
    logic [31:0]        r_ay;
    logic               r_sgx;
    logic               r_sgy;
    logic [63:0]        r_a2;
    logic [63:0]        r_d2;
    logic [31:0]        r_d;
    logic [31:0]        r_p;
    logic [63:0]        r_prod;

    t_out_word          r_out;
    logic               r_out_valid;

    // memory
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    t_entry             ram_wdata;
    logic [EW-1:0]      ram_rdata;
    t_entry             rd;

    // shared arithmetic
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [63:0]        div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;

    logic               in_accept;
    logic [31:0]        in_idx_ext;
    logic               in_range;
    logic [31:0]        count_ext;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic [31:0]        om;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [64:0]        d2_sum;
    logic [31:0]        p_sat;
    logic [31:0]        abs_sx;
    logic [31:0]        abs_sy;
    logic [63:0]        move_mag;
    logic               out_free;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] add_sat(input logic signed [31:0] base, input logic neg,
                                            input logic [63:0] mag);
        logic signed [65:0] b;
        logic signed [65:0] m;
        b = 66'(base);
        m = signed'({2'b00, mag});
        return sat32(neg ? b - m : b + m);
    endfunction

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign in_idx_ext = 32'(i_in_data.particle_index);
    assign in_range   = (in_idx_ext < MAX_PARTICLES);
    assign count_ext  = 32'(r_count);

    // hold the table in one memory; read the addressed entry, then walk the others
    assign rd        = t_entry'(ram_rdata);
    assign ram_raddr = (r_state == ST_IDLE) ? AW'(in_idx_ext) : r_k[AW-1:0];
    assign ram_we    = (in_accept && in_range && (i_in_data.req_type == REQ_LOAD)) ||
                       (r_state == ST_WB);
    assign ram_waddr = (r_state == ST_IDLE) ? AW'(in_idx_ext) : r_idx;

    always_comb begin
        if (r_state == ST_IDLE) begin
            ram_wdata.pos_x   = i_in_data.load_pos_x;
            ram_wdata.pos_y   = i_in_data.load_pos_y;
            ram_wdata.speed_x = i_in_data.load_speed_x;
            ram_wdata.speed_y = i_in_data.load_speed_y;
            ram_wdata.mass    = i_in_data.load_mass;
        end else begin
            ram_wdata.pos_x   = r_own_px;
            ram_wdata.pos_y   = r_own_py;
            ram_wdata.speed_x = r_own_sx;
            ram_wdata.speed_y = r_own_sy;
            ram_wdata.mass    = r_own_m;
        end
    end

    gps_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PARTICLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // the other body: a stored entry just read, or the attractor
    assign ox = (r_state == ST_RD_OTHER) ? rd.pos_x : r_attr_x;
    assign oy = (r_state == ST_RD_OTHER) ? rd.pos_y : r_attr_y;
    assign om = (r_state == ST_RD_OTHER) ? rd.mass  : r_attr_m;
    assign dx = 33'(ox) - 33'(r_own_px);
    assign dy = 33'(oy) - 33'(r_own_py);

    assign d2_sum = {1'b0, r_a2} + {1'b0, r_prod};
    assign p_sat  = (|div_quot[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
    assign abs_sx = r_own_sx[31] ? 32'(-r_own_sx) : r_own_sx;
    assign abs_sy = r_own_sy[31] ? 32'(-r_own_sy) : r_own_sy;
    assign move_mag = r_prod >> FRAC_BITS;

    // one 32x32 multiplier, operands picked by step
    always_comb begin
        case (r_state)
            ST_SQX:  begin mul_a = r_ax;     mul_b = r_ax;     end
            ST_SQY:  begin mul_a = r_ay;     mul_b = r_ay;     end
            ST_SQC:  begin mul_a = r_cutoff; mul_b = r_cutoff; end
            ST_MULX: begin mul_a = r_p;      mul_b = r_ax;     end
            ST_MULY: begin mul_a = r_p;      mul_b = r_ay;     end
            ST_DIVX: begin mul_a = r_p;      mul_b = r_ay;     end
            ST_MVX:  begin mul_a = abs_sx;   mul_b = r_tstep;  end
            ST_MVY:  begin mul_a = abs_sy;   mul_b = r_tstep;  end
            default: begin mul_a = r_om;     mul_b = r_tstep;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    gps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_CHK),
        .i_n     (r_d2),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // pull magnitude first, then each component over the root
    assign div_start = (r_state == ST_SQRT && sqrt_done) || (r_state == ST_MULY) ||
                       (r_state == ST_DIVX && div_done);
    assign div_num   = (r_state == ST_SQRT) ? {r_prod, {FRAC_BITS{1'b0}}} : NUM_W'(r_prod);
    assign div_den   = (r_state == ST_SQRT) ? r_d2 : 64'(r_d);

    gps_div #(
        .NUM_W (NUM_W),
        .DEN_W (64)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_x <= '0;
            r_attr_y <= '0;
            r_attr_m <= '0;
            r_tstep  <= 32'(1) << FRAC_BITS;
            r_cutoff <= '0;
            r_count  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ATTR_X: r_attr_x <= i_cfg_data;
                CFG_ATTR_Y: r_attr_y <= i_cfg_data;
                CFG_ATTR_M: r_attr_m <= i_cfg_data;
                CFG_TSTEP:  r_tstep  <= i_cfg_data;
                CFG_CUTOFF: r_cutoff <= i_cfg_data;
                CFG_COUNT:  r_count  <= i_cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the word once taken; the done step reloads it itself
            if (r_out_valid && !i_out_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_req   <= i_in_data.req_type;
                        r_pidx  <= i_in_data.particle_index;
                        r_idx   <= AW'(in_idx_ext);
                        r_lim   <= (count_ext > MAX_PARTICLES) ? KW'(MAX_PARTICLES)
                                                               : KW'(count_ext);
                        if (!in_range) begin
                            r_own_px <= '0;
                            r_own_py <= '0;
                            r_own_sx <= '0;
                            r_own_sy <= '0;
                            r_state  <= ST_DONE;
                        end else begin
                            r_own_px <= i_in_data.load_pos_x;
                            r_own_py <= i_in_data.load_pos_y;
                            r_own_sx <= i_in_data.load_speed_x;
                            r_own_sy <= i_in_data.load_speed_y;
                            if (i_in_data.req_type == REQ_LOAD) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_RD_OWN;
                            end
                        end
                    end
                end
                ST_RD_OWN: begin
                    r_own_px <= rd.pos_x;
                    r_own_py <= rd.pos_y;
                    r_own_sx <= rd.speed_x;
                    r_own_sy <= rd.speed_y;
                    r_own_m  <= rd.mass;
                    r_k      <= '0;
                    r_attr   <= 1'b0;
                    case (r_req)
                        REQ_SPEED: r_state <= ST_SCAN;
                        REQ_POS:   r_state <= ST_MVX;
                        default:   r_state <= ST_DONE;
                    endcase
                end
                ST_SCAN: begin
                    if (r_k >= r_lim) begin
                        // table done: take the attractor, no cutoff
                        r_attr  <= 1'b1;
                        r_om    <= om;
                        r_sgx   <= dx[32];
                        r_sgy   <= dy[32];
                        r_ax    <= dx[32] ? 32'(-dx) : dx[31:0];
                        r_ay    <= dy[32] ? 32'(-dy) : dy[31:0];
                        r_state <= ST_SQX;
                    end else if (r_k == KW'(r_idx)) begin
                        r_k <= r_k + KW'(1);
                    end else begin
                        r_state <= ST_RD_OTHER;
                    end
                end
                ST_RD_OTHER: begin
                    r_om    <= om;
                    r_sgx   <= dx[32];
                    r_sgy   <= dy[32];
                    r_ax    <= dx[32] ? 32'(-dx) : dx[31:0];
                    r_ay    <= dy[32] ? 32'(-dy) : dy[31:0];
                    r_k     <= r_k + KW'(1);
                    r_state <= ST_SQX;
                end
                ST_SQX: r_state <= ST_SQY;
                ST_SQY: begin
                    r_a2    <= r_prod;
                    r_state <= ST_SQC;
                end
                ST_SQC: begin
                    r_d2    <= d2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : d2_sum[63:0];
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    // drop pulls at zero distance, and stored bodies outside the cutoff
                    if (r_d2 == 64'd0 || (!r_attr && !(r_d2 < r_prod))) begin
                        r_state <= r_attr ? ST_WB : ST_SCAN;
                    end else begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        r_d     <= sqrt_root;
                        r_state <= ST_DIVP;
                    end
                end
                ST_DIVP: begin
                    if (div_done) begin
                        r_p     <= p_sat;
                        r_state <= ST_MULX;
                    end
                end
                ST_MULX: r_state <= ST_MULY;
                ST_MULY: r_state <= ST_DIVX;
                ST_DIVX: begin
                    if (div_done) begin
                        r_own_sx <= add_sat(r_own_sx, r_sgx, 64'(div_quot[31:0]));
                        r_state  <= ST_DIVY;
                    end
                end
                ST_DIVY: begin
                    if (div_done) begin
                        r_own_sy <= add_sat(r_own_sy, r_sgy, 64'(div_quot[31:0]));
                        r_state  <= r_attr ? ST_WB : ST_SCAN;
                    end
                end
                ST_MVX: r_state <= ST_MVY;
                ST_MVY: begin
                    r_own_px <= add_sat(r_own_px, r_own_sx[31], move_mag);
                    r_state  <= ST_MVEND;
                end
                ST_MVEND: begin
                    r_own_py <= add_sat(r_own_py, r_own_sy[31], move_mag);
                    r_state  <= ST_WB;
                end
                ST_WB: r_state <= ST_DONE;
                ST_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out.out_index   <= r_pidx;
                        r_out.out_pos_x   <= r_own_px;
                        r_out.out_pos_y   <= r_own_py;
                        r_out.out_speed_x <= r_own_sx;
                        r_out.out_speed_y <= r_own_sy;
                        r_out_valid       <= 1'b1;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
